@@ rtl/pst_pkg.sv @@
// shared widths, result codes and helpers for the point-on-segment test
// no dependencies; imported by pst_wide_mul and point_on_segment_test_unit
package pst_pkg;

  // coordinate and register widths
  localparam int COORD_BITS = 24;
  localparam int TOL_BITS   = 23;
  localparam int NUM_AXES   = 3;
  localparam int NUM_FIELDS = 3 * NUM_AXES;

  // stream payload widths
  localparam int S_DATA_W   = ((NUM_FIELDS * COORD_BITS + 7) / 8) * 8;
  localparam int M_DATA_W   = 8;

  // datapath widths
  localparam int DIFF_W     = COORD_BITS + 1;       // signed coordinate difference
  localparam int MUL_W      = 2 * DIFF_W;           // signed product of two differences
  localparam int SQ_W       = 2 * COORD_BITS + 1;   // one squared difference
  localparam int WIDE_W     = 2 * COORD_BITS + 2;   // squared length, sum of three
  localparam int DOT_W      = 2 * COORD_BITS + 3;   // signed dot product
  localparam int HALF_W     = WIDE_W / 2;           // operand split of the wide multiplier
  localparam int TOL2_W     = 2 * TOL_BITS;
  localparam int PROD_W     = 2 * WIDE_W;
  localparam int RHS_W      = PROD_W + 1;

  localparam logic [TOL_BITS-1:0] TOL_RESET = TOL_BITS'(16);

  // contact codes on the result stream
  typedef enum logic [1:0] {
    CONTACT_NONE   = 2'd0,
    CONTACT_EDGE   = 2'd1,
    CONTACT_VERTEX = 2'd2
  } contact_e;

  // flags carried alongside the wide products
  typedef struct packed {
    logic vertex;
    logic edge_ok;
  } pst_flags_t;

endpackage

@@ rtl/pst_wide_mul.sv @@
// two-stage unsigned WIDE_W x WIDE_W multiplier built from four half-width partials
// depends on pst_pkg; used three times by point_on_segment_test_unit
module pst_wide_mul import pst_pkg::*; (
  input  logic              clk_i,
  input  logic              en_pp_i,   // advance the partial product stage
  input  logic              en_sum_i,  // advance the combine stage
  input  logic [WIDE_W-1:0] a_i,
  input  logic [WIDE_W-1:0] b_i,
  output logic [PROD_W-1:0] p_o
);

  logic [2*HALF_W-1:0] ll_q, lh_q, hl_q, hh_q;
  logic [2*HALF_W:0]   mid;
  logic [PROD_W-1:0]   p_q;

  // partial products of the low and high halves
  always_ff @(posedge clk_i) begin
    if (en_pp_i) begin
      ll_q <= a_i[HALF_W-1:0]      * b_i[HALF_W-1:0];
      lh_q <= a_i[HALF_W-1:0]      * b_i[WIDE_W-1:HALF_W];
      hl_q <= a_i[WIDE_W-1:HALF_W] * b_i[HALF_W-1:0];
      hh_q <= a_i[WIDE_W-1:HALF_W] * b_i[WIDE_W-1:HALF_W];
    end
  end

  // shift and add the partials
  assign mid = {1'b0, lh_q} + {1'b0, hl_q};

  always_ff @(posedge clk_i) begin
    if (en_sum_i) begin
      p_q <= {hh_q, ll_q} + (PROD_W'(mid) << HALF_W);
    end
  end

  assign p_o = p_q;

endmodule

@@ rtl/point_on_segment_test_unit.sv @@
// top level of the point-on-segment contact test: seven-stage pipeline
// depends on pst_pkg and pst_wide_mul
//
// Each input item carries a point P and edge endpoints A and B (nine signed
// coordinates) and yields one contact code: 2 when P is strictly within the
// tolerance of A or B, 1 when the edge is longer than the tolerance, P projects
// inside the edge and its perpendicular distance is below the tolerance, else 0.
// All tests use exact squared integers. The unit takes one item per clock when the
// output is not stalled; the pipeline depth is set by the three-level multiply
// chain (differences, squares and dot product, then the split 50x50 products for
// the perpendicular test). Each stage holds while the next is full and stalled, so
// bubbles close up. The tolerance register resets to 16; the user must write it
// only while the unit is idle, which the unit itself does not enforce.
module point_on_segment_test_unit import pst_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // tolerance register
  input  logic                cfg_we_i,
  input  logic [TOL_BITS-1:0] cfg_wdata_i,
  // input items
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // point_x, point_y, point_z, end_a_x, end_a_y, end_a_z, end_b_x, end_b_y, end_b_z
  input  logic [S_DATA_W-1:0] s_axis_tdata,
  // result items
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // contact, zero fill above
  output logic [M_DATA_W-1:0] m_axis_tdata
);

  localparam int NSTAGE = 7;

  logic [TOL_BITS-1:0] tol_q;
  logic [TOL2_W-1:0]   tol2_q;
  logic [NSTAGE:1]     v_q;
  logic [NSTAGE:1]     en;

  // tolerance register and its square
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q  <= TOL_RESET;
      tol2_q <= TOL2_W'(TOL_RESET) * TOL2_W'(TOL_RESET);
    end else begin
      if (cfg_we_i) tol_q <= cfg_wdata_i;
      tol2_q <= TOL2_W'(tol_q) * TOL2_W'(tol_q);
    end
  end

  // stage enables: a stage moves when empty or when the next one moves
  always_comb begin
    en[NSTAGE] = !v_q[NSTAGE] || m_axis_tready;
    for (int k = NSTAGE - 1; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign s_axis_tready = en[1];

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) v_q[1] <= s_axis_tvalid;
      for (int k = 2; k <= NSTAGE; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // stage 1: coordinate differences
  logic signed [DIFF_W-1:0] pa_q [NUM_AXES];
  logic signed [DIFF_W-1:0] pb_q [NUM_AXES];
  logic signed [DIFF_W-1:0] ab_q [NUM_AXES];

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        pa_q[i] <= $signed(DIFF_W'($signed(s_axis_tdata[i*COORD_BITS +: COORD_BITS])))
                 - $signed(DIFF_W'($signed(s_axis_tdata[(i+3)*COORD_BITS +: COORD_BITS])));
        pb_q[i] <= $signed(DIFF_W'($signed(s_axis_tdata[i*COORD_BITS +: COORD_BITS])))
                 - $signed(DIFF_W'($signed(s_axis_tdata[(i+6)*COORD_BITS +: COORD_BITS])));
        ab_q[i] <= $signed(DIFF_W'($signed(s_axis_tdata[(i+3)*COORD_BITS +: COORD_BITS])))
                 - $signed(DIFF_W'($signed(s_axis_tdata[(i+6)*COORD_BITS +: COORD_BITS])));
      end
    end
  end

  // stage 2: squares and dot product terms
  logic [SQ_W-1:0]         pa_sq_q [NUM_AXES];
  logic [SQ_W-1:0]         pb_sq_q [NUM_AXES];
  logic [SQ_W-1:0]         ab_sq_q [NUM_AXES];
  logic signed [MUL_W-1:0] dot_q   [NUM_AXES];
  logic signed [MUL_W-1:0] pa_m    [NUM_AXES];
  logic signed [MUL_W-1:0] pb_m    [NUM_AXES];
  logic signed [MUL_W-1:0] ab_m    [NUM_AXES];

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      pa_m[i] = pa_q[i] * pa_q[i];
      pb_m[i] = pb_q[i] * pb_q[i];
      ab_m[i] = ab_q[i] * ab_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        pa_sq_q[i] <= pa_m[i][SQ_W-1:0];
        pb_sq_q[i] <= pb_m[i][SQ_W-1:0];
        ab_sq_q[i] <= ab_m[i][SQ_W-1:0];
        dot_q[i]   <= pb_q[i] * ab_q[i];
      end
    end
  end

  // stage 3: squared lengths and projection numerator
  logic [WIDE_W-1:0]       pa2_q, pb2_q, ab2_q;
  logic signed [DOT_W-1:0] t_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      pa2_q <= WIDE_W'(pa_sq_q[0]) + WIDE_W'(pa_sq_q[1]) + WIDE_W'(pa_sq_q[2]);
      pb2_q <= WIDE_W'(pb_sq_q[0]) + WIDE_W'(pb_sq_q[1]) + WIDE_W'(pb_sq_q[2]);
      ab2_q <= WIDE_W'(ab_sq_q[0]) + WIDE_W'(ab_sq_q[1]) + WIDE_W'(ab_sq_q[2]);
      t_q   <= DOT_W'(dot_q[0]) + DOT_W'(dot_q[1]) + DOT_W'(dot_q[2]);
    end
  end

  // stage 4: vertex, length and parameter tests; multipliers take their partials
  logic [WIDE_W-1:0] tol2_w;
  pst_flags_t        flags_d, flags4_q, flags5_q, flags6_q;

  assign tol2_w = WIDE_W'(tol2_q);

  always_comb begin
    flags_d.vertex  = (pa2_q < tol2_w) || (pb2_q < tol2_w);
    flags_d.edge_ok = (ab2_q > tol2_w) && !t_q[DOT_W-1]
                      && ($unsigned(t_q) <= DOT_W'(ab2_q));
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) flags4_q <= flags_d;
    if (en[5]) flags5_q <= flags4_q;
    if (en[6]) flags6_q <= flags5_q;
  end

  // stages 4 and 5: split wide products
  logic [PROD_W-1:0] lhs_p, tol_p, tsq_p;

  pst_wide_mul u_mul_lhs (
    .clk_i    (clk_i),
    .en_pp_i  (en[4]),
    .en_sum_i (en[5]),
    .a_i      (pb2_q),
    .b_i      (ab2_q),
    .p_o      (lhs_p)
  );

  pst_wide_mul u_mul_tol (
    .clk_i    (clk_i),
    .en_pp_i  (en[4]),
    .en_sum_i (en[5]),
    .a_i      (tol2_w),
    .b_i      (ab2_q),
    .p_o      (tol_p)
  );

  pst_wide_mul u_mul_tsq (
    .clk_i    (clk_i),
    .en_pp_i  (en[4]),
    .en_sum_i (en[5]),
    .a_i      (t_q[WIDE_W-1:0]),
    .b_i      (t_q[WIDE_W-1:0]),
    .p_o      (tsq_p)
  );

  // stage 6: both sides of the perpendicular test
  logic [PROD_W-1:0] lhs_q;
  logic [RHS_W-1:0]  rhs_q;

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      lhs_q <= lhs_p;
      rhs_q <= RHS_W'(tol_p) + RHS_W'(tsq_p);
    end
  end

  // stage 7: final decision into the output register
  contact_e contact_d, contact_q;

  always_comb begin
    if (flags6_q.vertex) begin
      contact_d = CONTACT_VERTEX;
    end else if (flags6_q.edge_ok && (RHS_W'(lhs_q) < rhs_q)) begin
      contact_d = CONTACT_EDGE;
    end else begin
      contact_d = CONTACT_NONE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[7]) contact_q <= contact_d;
  end

  assign m_axis_tvalid = v_q[NSTAGE];
  assign m_axis_tdata  = M_DATA_W'(contact_q);

endmodule
